[hw/rtl/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, widths and constants of the Euler-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int QUAT_BITS  = 16;

  // CORDIC datapath: Q30 with headroom for the range fold
  localparam int CW    = 34;
  localparam int SCW   = 32;
  localparam int PW    = 64;
  localparam int SW    = 65;
  localparam int ITERS = 30;

  localparam int SC_LAT  = ITERS + 2;
  localparam int CMB_LAT = 5;
  localparam int LAT     = SC_LAT + CMB_LAT;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);
  localparam logic signed [CW-1:0] Q30_PI      = CW'(64'sd3373259426);
  localparam logic signed [CW-1:0] Q30_HALF_PI = CW'(64'sd1686629713);

  localparam logic signed [SW-1:0]      ROUND_BIAS = SW'(1) <<< (61 - QUAT_BITS);
  localparam logic signed [SW-1:0]      SAT_HI     = SW'(1) <<< (QUAT_BITS - 2);
  localparam logic signed [SW-1:0]      SAT_LO     = -SAT_HI;
  localparam logic signed [QUAT_BITS:0] QUAT_ONE   = (QUAT_BITS + 1)'(1) <<< (QUAT_BITS - 2);

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } angle_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [SCW-1:0] sin_v;
    logic signed [SCW-1:0] cos_v;
  } sincos_t;

  // arctan(2^-i) in Q30
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return CW'(v);
  endfunction

endpackage

[hw/rtl/e2q_sincos.sv]
// ----------------------------------------------------------------------------
// e2q_sincos
// Pipelined rotation-mode CORDIC: sine and cosine of half the input angle.
// ----------------------------------------------------------------------------
module e2q_sincos import e2q_pkg::*; (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output sincos_t                      sc
);

  logic signed [CW-1:0] x_q [0:ITERS];
  logic signed [CW-1:0] y_q [0:ITERS];
  logic signed [CW-1:0] z_q [0:ITERS];
  logic                 neg_q [0:ITERS];

  logic signed [CW-1:0] h;
  logic signed [CW-1:0] z_fold;
  logic                 neg_fold;
  logic signed [CW-1:0] cos_full;

  // half angle in Q30, then fold into [-pi/2, pi/2]
  assign h = CW'(angle) <<< (32 - ANGLE_BITS);

  always_comb begin
    z_fold   = h;
    neg_fold = 1'b0;
    if (h > Q30_HALF_PI) begin
      z_fold   = Q30_PI - h;
      neg_fold = 1'b1;
    end else if (h < -Q30_HALF_PI) begin
      z_fold   = -Q30_PI - h;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0]   <= CORDIC_GAIN;
      y_q[0]   <= '0;
      z_q[0]   <= z_fold;
      neg_q[0] <= neg_fold;
    end
  end

  for (genvar k = 0; k < ITERS; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        neg_q[k+1] <= neg_q[k];
        if (!z_q[k][CW-1]) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - atan_q30(k);
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + atan_q30(k);
        end
      end
    end
  end

  assign cos_full = neg_q[ITERS] ? -x_q[ITERS] : x_q[ITERS];

  always_ff @(posedge clk) begin
    if (en) begin
      sc.sin_v <= y_q[ITERS][SCW-1:0];
      sc.cos_v <= cos_full[SCW-1:0];
    end
  end

endmodule

[hw/rtl/e2q_combine.sv]
// ----------------------------------------------------------------------------
// e2q_combine
// Multiply half-angle sines and cosines into ZYX quaternion components.
// ----------------------------------------------------------------------------
module e2q_combine import e2q_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  sincos_t roll,
  input  sincos_t pitch,
  input  sincos_t yaw,
  output quat_t   quat
);

  // first products: roll x pitch
  logic signed [PW-1:0]  p_cc, p_ss, p_sc, p_cs;
  logic signed [SCW-1:0] cy_d1, sy_d1, cy_d2, sy_d2;
  logic signed [PW-1:0]  rnd_cc, rnd_ss, rnd_sc, rnd_cs;
  logic signed [SCW-1:0] m_cc, m_ss, m_sc, m_cs;
  // second products with yaw
  logic signed [PW-1:0]  w_a, w_b, x_a, x_b, y_a, y_b, z_a, z_b;
  logic signed [SW-1:0]  s_w, s_x, s_y, s_z;

  function automatic logic signed [QUAT_BITS-1:0] to_out(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    r = (s + ROUND_BIAS) >>> (62 - QUAT_BITS);
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[QUAT_BITS-1:0];
  endfunction

  assign rnd_cc = p_cc + (PW'(1) <<< 29);
  assign rnd_ss = p_ss + (PW'(1) <<< 29);
  assign rnd_sc = p_sc + (PW'(1) <<< 29);
  assign rnd_cs = p_cs + (PW'(1) <<< 29);

  always_ff @(posedge clk) begin
    if (en) begin
      p_cc  <= roll.cos_v * pitch.cos_v;
      p_ss  <= roll.sin_v * pitch.sin_v;
      p_sc  <= roll.sin_v * pitch.cos_v;
      p_cs  <= roll.cos_v * pitch.sin_v;
      cy_d1 <= yaw.cos_v;
      sy_d1 <= yaw.sin_v;

      m_cc  <= SCW'(rnd_cc >>> 30);
      m_ss  <= SCW'(rnd_ss >>> 30);
      m_sc  <= SCW'(rnd_sc >>> 30);
      m_cs  <= SCW'(rnd_cs >>> 30);
      cy_d2 <= cy_d1;
      sy_d2 <= sy_d1;

      w_a <= m_cc * cy_d2;
      w_b <= m_ss * sy_d2;
      x_a <= m_sc * cy_d2;
      x_b <= m_cs * sy_d2;
      y_a <= m_cs * cy_d2;
      y_b <= m_sc * sy_d2;
      z_a <= m_cc * sy_d2;
      z_b <= m_ss * cy_d2;

      s_w <= SW'(w_a) + SW'(w_b);
      s_x <= SW'(x_a) - SW'(x_b);
      s_y <= SW'(y_a) + SW'(y_b);
      s_z <= SW'(z_a) - SW'(z_b);

      quat.quat_w <= to_out(s_w);
      quat.quat_x <= to_out(s_x);
      quat.quat_y <= to_out(s_y);
      quat.quat_z <= to_out(s_z);
    end
  end

endmodule

[hw/rtl/euler_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Roll, pitch, yaw (Q3.13 rad) to the ZYX unit quaternion (Q2.14).
// ----------------------------------------------------------------------------
// Usage:
//   The angle channel (angle_valid / angle_ready / angle) carries one attitude
//   sample per transaction; the quat channel (quat_valid / quat_ready / quat)
//   returns w, x, y, z for it, in order, one result per sample.
//   From accepted sample to quat_valid a sample passes one fold stage,
//   30 CORDIC iteration stages and one output stage per angle lane (the three
//   angles run in parallel lanes), then five multiply/round stages.
//   Throughput is one transaction per cycle while quat is taken every cycle;
//   the depth of the CORDIC and multiply/round pipeline sets the latency.
//   All stages advance together on one enable. When the receiver stalls with
//   a result waiting, the whole pipeline holds and angle_ready drops; nothing
//   is dropped or repeated. Empty stages inside the pipeline hold as well, so
//   no sample enters until the waiting result is taken.
//   Reset (rst, synchronous) clears only the valid bits; data registers are
//   not reset. No configuration.
// ----------------------------------------------------------------------------
module euler_to_quaternion import e2q_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   angle_valid,
  output logic   angle_ready,
  input  angle_t angle,
  output logic   quat_valid,
  input  logic   quat_ready,
  output quat_t  quat
);

  logic [LAT-1:0] vld;
  logic           adv;
  sincos_t        sc_roll, sc_pitch, sc_yaw;

  // advance every stage whenever the output register is free or drained
  assign adv         = !vld[LAT-1] || quat_ready;
  assign angle_ready = adv;
  assign quat_valid  = vld[LAT-1];

  // valid bits travel with the data through every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], angle_valid};
    end
  end

  // one CORDIC lane per angle
  e2q_sincos u_roll (
    .clk   (clk),
    .en    (adv),
    .angle (angle.roll_angle),
    .sc    (sc_roll)
  );

  e2q_sincos u_pitch (
    .clk   (clk),
    .en    (adv),
    .angle (angle.pitch_angle),
    .sc    (sc_pitch)
  );

  e2q_sincos u_yaw (
    .clk   (clk),
    .en    (adv),
    .angle (angle.yaw_angle),
    .sc    (sc_yaw)
  );

  // combine into w, x, y, z; last stage is the output register
  e2q_combine u_combine (
    .clk   (clk),
    .en    (adv),
    .roll  (sc_roll),
    .pitch (sc_pitch),
    .yaw   (sc_yaw),
    .quat  (quat)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> !quat_valid && vld == '0)
    else $error("pipeline valid bits not cleared by reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    angle_valid && angle_ready |=> vld[0])
    else $error("accepted transaction did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while stalled");

  a_w_saturated: assert property (@(posedge clk) disable iff (rst)
    quat_valid |-> ((QUAT_BITS + 1)'(quat.quat_w) <= QUAT_ONE) &&
                   ((QUAT_BITS + 1)'(quat.quat_w) >= -QUAT_ONE))
    else $error("quat_w outside +-1.0");

  a_z_saturated: assert property (@(posedge clk) disable iff (rst)
    quat_valid |-> ((QUAT_BITS + 1)'(quat.quat_z) <= QUAT_ONE) &&
                   ((QUAT_BITS + 1)'(quat.quat_z) >= -QUAT_ONE))
    else $error("quat_z outside +-1.0");

endmodule
